### hdl/mie_pkg.sv
// Shared constants and controller/datapath handshake types for the modular inverse block.
`timescale 1ns / 1ps
package mie_pkg;

  localparam int unsigned WIDTH_DEF = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture value and modulus, seed the recurrence
    logic div_init;   // start a quotient/remainder pass on r0 / r1
    logic div_step;   // one restoring-division bit
    logic update;     // shift the recurrence by one Euclid step
    logic reduce;     // fold the coefficient below the modulus
    logic finish;     // apply the sign and write the result registers
  } mie_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic r1_zero;    // divisor of the next step is zero: recurrence done
    logic div_last;   // current division bit is the last one
  } mie_sts_t;

endpackage

### hdl/mie_in_if.sv
// Input channel: value and modulus with a valid/ready handshake.
`timescale 1ns / 1ps
interface mie_in_if #(
  parameter int unsigned WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;
  logic [WIDTH-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface

### hdl/mie_out_if.sv
// Result channel: inverse, exists flag and gcd with a valid/ready handshake.
`timescale 1ns / 1ps
interface mie_out_if #(
  parameter int unsigned WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] inverse;
  logic             exists;
  logic [WIDTH-1:0] divisor;

  modport source (output valid, output inverse, output exists, output divisor, input ready);
  modport sink   (input valid, input inverse, input exists, input divisor, output ready);
endinterface

### hdl/mie_dpath.sv
// Datapath: Euclid recurrence registers, serial divider with shift-add coefficient update.
`timescale 1ns / 1ps
module mie_dpath #(
  parameter int unsigned WIDTH = 32
) (
  input  logic               clk,
  input  mie_pkg::mie_cmd_t  cmd,
  output mie_pkg::mie_sts_t  sts,
  input  logic [WIDTH-1:0]   value,
  input  logic [WIDTH-1:0]   modulus,
  output logic [WIDTH-1:0]   inverse,
  output logic               exists,
  output logic [WIDTH-1:0]   divisor
);
  import mie_pkg::*;

  localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] r0_r, r1_r, u0_r, u1_r, mod_r;
  logic [WIDTH-1:0] rem_r, shf_r, acc_r, red_r;
  logic             par_r;
  logic [CW-1:0]    cnt_r;
  logic [WIDTH-1:0] inv_r, div_r;
  logic             ok_r;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             ge;
  logic [WIDTH-1:0] rem_nxt;
  logic [WIDTH-1:0] acc_nxt;
  logic             ok;
  logic [WIDTH-1:0] red_nxt;
  logic [WIDTH-1:0] inv_nxt;

  // One restoring-division bit; the quotient bit feeds the coefficient product
  always_comb begin
    trial   = {rem_r, shf_r[WIDTH-1]};
    diff    = trial - {1'b0, r1_r};
    ge      = ~diff[WIDTH];
    rem_nxt = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    acc_nxt = {acc_r[WIDTH-2:0], 1'b0} + (ge ? u1_r : '0);
  end

  always_comb begin
    ok      = (mod_r != '0) && (r0_r == WIDTH'(1));
    red_nxt = (u0_r >= mod_r) ? (u0_r - mod_r) : u0_r;
    if (!ok) begin
      inv_nxt = '0;
    end else if (par_r && (red_r != '0)) begin
      inv_nxt = mod_r - red_r;
    end else begin
      inv_nxt = red_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r0_r  <= value;
      r1_r  <= modulus;
      mod_r <= modulus;
      u0_r  <= WIDTH'(1);
      u1_r  <= '0;
      par_r <= 1'b0;
    end
    if (cmd.div_init) begin
      shf_r <= r0_r;
      rem_r <= '0;
      acc_r <= '0;
      cnt_r <= CW'(WIDTH - 1);
    end
    if (cmd.div_step) begin
      shf_r <= {shf_r[WIDTH-2:0], 1'b0};
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
      cnt_r <= cnt_r - CW'(1);
    end
    if (cmd.update) begin
      r0_r  <= r1_r;
      r1_r  <= rem_r;
      u0_r  <= u1_r;
      u1_r  <= acc_r + u0_r;
      par_r <= ~par_r;
    end
    if (cmd.reduce) begin
      red_r <= red_nxt;
    end
    if (cmd.finish) begin
      inv_r <= inv_nxt;
      ok_r  <= ok;
      div_r <= r0_r;
    end
  end

  assign sts.r1_zero  = (r1_r == '0);
  assign sts.div_last = (cnt_r == '0);

  assign inverse = inv_r;
  assign exists  = ok_r;
  assign divisor = div_r;

endmodule

### hdl/mie_ctrl.sv
// Controller: sequences load, division passes, recurrence updates and result hand-off.
`timescale 1ns / 1ps
module mie_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  mie_pkg::mie_sts_t  sts,
  output mie_pkg::mie_cmd_t  cmd
);
  import mie_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV,
    ST_UPD,
    ST_RED,
    ST_FIN
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   fin_go;

  // Result register is free when empty or being drained this cycle
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    cmd          = '0;
    cmd.load     = in_valid && in_ready;
    cmd.div_init = (state_r == ST_TEST) && !sts.r1_zero;
    cmd.div_step = (state_r == ST_DIV);
    cmd.update   = (state_r == ST_UPD);
    cmd.reduce   = (state_r == ST_RED);
    cmd.finish   = fin_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // Drop valid once the word is taken, unless a new one moves in at the same edge
      if (out_valid_r && out_ready && !fin_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready_r) begin
            in_ready_r <= 1'b0;
            state_r    <= ST_TEST;
          end
        end
        ST_TEST: begin
          state_r <= sts.r1_zero ? ST_RED : ST_DIV;
        end
        ST_DIV: begin
          if (sts.div_last) begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          state_r <= ST_TEST;
        end
        ST_RED: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            out_valid_r <= 1'b1;
            in_ready_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  // Hold ready low while reset is asserted so no word is taken and lost
  assign in_ready  = in_ready_r && rst_n;
  assign out_valid = out_valid_r;

endmodule

### hdl/modular_inverse_ext_euclid_top.sv
// Top level of the modular inverse block: extended Euclid with a serial divider.
`timescale 1ns / 1ps
// Takes one word of (value, modulus) and returns one word of (inverse, exists, divisor).
// divisor is gcd(value, modulus); when it is 1 and the modulus is nonzero, exists is set
// and inverse is the inverse of value in 0 .. modulus-1, else inverse is 0. The block
// works on one word at a time. Each Euclid step runs a restoring division of WIDTH
// quotient bits, then an update and a test. The number of Euclid steps is at most
// about 1.44*WIDTH+2, and the serial divider sets how long an item takes. A finished
// word waits in the result register while the next word is accepted and worked on;
// only the hand-off into that register stalls on out_ready.
module modular_inverse_ext_euclid_top #(
  parameter int unsigned WIDTH = mie_pkg::WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mie_in_if.sink     in_ch,
  mie_out_if.source  out_ch
);
  import mie_pkg::*;

  mie_cmd_t cmd;
  mie_sts_t sts;

  // Sequencing: load, test, divide, update, reduce, finish
  mie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Remainders, Bezout coefficient magnitude and sign parity, result registers
  mie_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk     (clk),
    .cmd     (cmd),
    .sts     (sts),
    .value   (in_ch.value),
    .modulus (in_ch.modulus),
    .inverse (out_ch.inverse),
    .exists  (out_ch.exists),
    .divisor (out_ch.divisor)
  );

  // Hold off a second word until the current one is finished
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while a word is still in work");

  // An inverse only exists for a unit gcd
  a_exists_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.exists |-> out_ch.divisor == WIDTH'(1))
    else $error("exists set with gcd other than one");

  // No inverse: the field reads zero
  a_no_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.exists |-> out_ch.inverse == '0)
    else $error("inverse nonzero without exists");

endmodule

### tb/sv/tb_top.sv
// Testbench for the modular inverse block: random and corner-case words checked against a local Euclid model.
`timescale 1ns / 1ps

// Predicts each result word from the input word and keeps the expected words in order.
class inverse_scoreboard;
  localparam int unsigned W = mie_pkg::WIDTH_DEF;

  typedef struct {
    logic [W-1:0] inverse;
    logic         exists;
    logic [W-1:0] divisor;
  } inverse_word_t;

  inverse_word_t expected_inverses[$];
  int            mismatches;

  function new();
    mismatches = 0;
  endfunction

  // Extended Euclid with the coefficient of the value kept as a magnitude;
  // its sign flips on every step.
  static function inverse_word_t euclid_inverse(logic [W-1:0] value, logic [W-1:0] modulus);
    bit [63:0]     r0, r1, r2, q, u0, u1, u2, red;
    bit            negative;
    int            steps;
    inverse_word_t res;
    r0       = 64'(value);
    r1       = 64'(modulus);
    u0       = 64'd1;
    u1       = 64'd0;
    negative = 1'b0;
    steps    = 0;
    while (r1 != 0 && steps < 2 * W + 4) begin
      q        = r0 / r1;
      r2       = r0 % r1;
      u2       = u0 + q * u1;
      r0       = r1;
      r1       = r2;
      u0       = u1;
      u1       = u2;
      negative = ~negative;
      steps++;
    end
    res.divisor = r0[W-1:0];
    res.inverse = '0;
    res.exists  = 1'b0;
    if (modulus != 0 && r0 == 64'd1) begin
      red = u0 % 64'(modulus);
      if (negative && red != 0) red = 64'(modulus) - red;
      res.inverse = red[W-1:0];
      res.exists  = 1'b1;
    end
    return res;
  endfunction

  function void note_input(logic [W-1:0] value, logic [W-1:0] modulus);
    expected_inverses.push_back(euclid_inverse(value, modulus));
  endfunction

  function void check_result(logic [W-1:0] inverse, logic exists, logic [W-1:0] divisor);
    inverse_word_t exp_word;
    if (expected_inverses.size() == 0) begin
      $display("%0t: result word with nothing expected: inverse %h exists %b divisor %h",
               $time, inverse, exists, divisor);
      mismatches++;
      return;
    end
    exp_word = expected_inverses.pop_front();
    if (inverse !== exp_word.inverse) begin
      $display("%0t: inverse mismatch: expected %h, got %h", $time, exp_word.inverse, inverse);
      mismatches++;
    end
    if (exists !== exp_word.exists) begin
      $display("%0t: exists mismatch: expected %b, got %b", $time, exp_word.exists, exists);
      mismatches++;
    end
    if (divisor !== exp_word.divisor) begin
      $display("%0t: divisor mismatch: expected %h, got %h", $time, exp_word.divisor, divisor);
      mismatches++;
    end
  endfunction

  function int outstanding();
    return expected_inverses.size();
  endfunction
endclass

module tb_top;
  localparam int unsigned W = mie_pkg::WIDTH_DEF;

  // The limit allows several times the worst case of every item plus the longest gaps on
  // both sides before calling it a hang.
  localparam int LIMIT_CYCLES  = 4_000_000;
  // Wait one worst-case item past the last result to catch a stray extra word.
  localparam int DRAIN_CYCLES  = 1800;
  localparam int RANDOM_ITEMS  = 350;
  // Receiver hold-off: long enough for the block to finish one word, park it in the
  // result register, finish a second and stall its input.
  localparam int HOLD_AT       = 40;
  localparam int HOLD_CYCLES   = 6000;

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   sent = 0;
  bit   eager_send = 1'b0;

  inverse_scoreboard sb = new();

  mie_in_if  #(.WIDTH(W)) in_ch ();
  mie_out_if #(.WIDTH(W)) out_ch ();

  modular_inverse_ext_euclid_top #(.WIDTH(W)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hang guard: count every edge and bail out well past the slowest correct run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Idle length for either side: mostly none or short, now and then long.
  // In an eager stretch return zero so back-to-back words get exercised.
  function automatic int idle_cycles(bit eager);
    int pick;
    if (eager) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // Offer one word and hold it until the block takes it. Lower valid only when a gap
  // comes first, so valid never gets two assignments in one step.
  task automatic offer_pair(input logic [W-1:0] value, input logic [W-1:0] modulus);
    int gap;
    gap = idle_cycles(eager_send);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= value;
    in_ch.modulus <= modulus;
    // ready is read right after the edge, so it is the value the edge saw.
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_input(value, modulus);
    sent++;
  endtask

  // Consecutive Fibonacci numbers are the longest Euclid chains for their size.
  function automatic void fib_pair(input int k, output logic [W-1:0] lo, output logic [W-1:0] hi);
    logic [W-1:0] a, b, c;
    a = 1;
    b = 1;
    repeat (k) begin
      c = a + b;
      a = b;
      b = c;
    end
    lo = a;
    hi = b;
  endfunction

  // Random word, weighted toward the cases that steer the algorithm somewhere
  // interesting: shared factors, zero and unit moduli, long chains, value above modulus.
  task automatic random_pair(output logic [W-1:0] value, output logic [W-1:0] modulus);
    int           pick;
    logic [W-1:0] g, lo, hi;
    pick    = $urandom_range(0, 99);
    value   = $urandom();
    modulus = $urandom();
    if (pick < 45) begin
      // full-range random, leave as is
    end else if (pick < 55) begin
      value   = $urandom_range(0, 255);
      modulus = $urandom_range(0, 255);
    end else if (pick < 65) begin
      // force a common factor
      g       = $urandom_range(2, 65535);
      value   = g * $urandom_range(0, 65535);
      modulus = g * $urandom_range(1, 65535);
    end else if (pick < 72) begin
      modulus = 32'hFFFF_FFFB;
    end else if (pick < 80) begin
      // value at or above the modulus
      modulus = value >> $urandom_range(1, W - 1);
    end else if (pick < 86) begin
      modulus = $urandom_range(0, 1);
    end else if (pick < 93) begin
      fib_pair($urandom_range(20, 45), lo, hi);
      if ($urandom_range(0, 1) == 1) begin
        value   = lo;
        modulus = hi;
      end else begin
        value   = hi;
        modulus = lo;
      end
    end else begin
      value = ($urandom_range(0, 1) == 1) ? '1 : '0;
      if ($urandom_range(0, 1) == 1) modulus = '1;
    end
  endtask

  // Result side: check each word taken, then stall for a while; once, hold off long
  // enough to back the block up into its input.
  initial begin : result_sink
    int stall;
    int taken;
    stall = 0;
    taken = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        sb.check_result(out_ch.inverse, out_ch.exists, out_ch.divisor);
        taken++;
        if (taken == HOLD_AT) stall = HOLD_CYCLES;
        else stall = idle_cycles((taken % 50) < 10);
      end else if (stall == 0 && $urandom_range(0, 31) == 0) begin
        // drop ready now and then while nothing is offered too
        stall = idle_cycles(1'b0);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [W-1:0] value, modulus;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.value   <= '0;
    in_ch.modulus <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner cases: zero modulus, both zero, modulus one, gcd above one,
    // value at or above the modulus, extremes of both fields, longest chains.
    offer_pair(32'd0, 32'd0);
    offer_pair(32'd12345, 32'd0);
    offer_pair(32'hFFFF_FFFF, 32'd0);
    offer_pair(32'd0, 32'd1);
    offer_pair(32'hFFFF_FFFF, 32'd1);
    offer_pair(32'd0, 32'd7);
    offer_pair(32'd3, 32'd7);
    offer_pair(32'd10, 32'd7);
    offer_pair(32'd7, 32'd7);
    offer_pair(32'd6, 32'd9);
    offer_pair(32'd1, 32'd2);
    offer_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    offer_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    offer_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_pair(32'h8000_0000, 32'hFFFF_FFFF);
    offer_pair(32'd2, 32'h8000_0000);
    offer_pair(32'd1836311903, 32'd2971215073);
    offer_pair(32'd2971215073, 32'd1836311903);
    offer_pair(32'hDEAD_BEEF, 32'hFFFF_FFFB);
    offer_pair(32'd1, 32'hFFFF_FFFF);
    offer_pair(32'h1234_5678, 32'h9ABC_DEF1);

    repeat (RANDOM_ITEMS) begin
      // run a burst with no sender gaps every so often
      eager_send = (sent % 60) < 12;
      random_pair(value, modulus);
      offer_pair(value, modulus);
    end
    in_ch.valid <= 1'b0;

    // Drain: wait out every expected word, then idle past one item's latency.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
